// ===== hw/rtl/mexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by mexp_mulmod and modular_exponentiation.
package mexp_pkg;

   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } mulmod_status_type;

endpackage

// ===== hw/rtl/mexp_mulmod.sv =====
`timescale 1ns / 1ps
// Shared modular multiplier: one product register and a shift-subtract reducer.
// Depends on mexp_pkg for the status struct.
module mexp_mulmod #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [OPERAND_WIDTH-1:0]     op_a,
   input  logic [OPERAND_WIDTH-1:0]     op_b,
   input  logic [OPERAND_WIDTH-1:0]     modulus,
   output mexp_pkg::mulmod_status_type  status,
   output logic [OPERAND_WIDTH-1:0]     result
);
   import mexp_pkg::*;

   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int CW = $clog2(PW + 1);

   logic [PW-1:0]            prod_ff, prod_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [OPERAND_WIDTH:0]   trial;
   logic [OPERAND_WIDTH:0]   diff;

   assign trial = {rem_ff, prod_ff[PW-1]};
   assign diff  = trial - {1'b0, modulus};

   always_comb begin
      prod_in = prod_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         prod_in = PW'(op_a) * PW'(op_b);
         rem_in  = '0;
         cnt_in  = CW'(PW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {prod_ff[PW-2:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = diff[OPERAND_WIDTH-1:0];
         end else begin
            rem_in = trial[OPERAND_WIDTH-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = rem_ff;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Modular exponentiation top level: sequencer, operand registers and output register.
// Depends on mexp_pkg and mexp_mulmod.
//
// Usage: a request beat on req_ carries base, exponent and modulus; one response
// beat on rsp_ carries base^exponent mod modulus and a zero-modulus error flag.
// The exponent is scanned from its least significant bit. Each scanned bit passes
// through the scan state, one modular squaring and, when the bit is set, one
// modular multiply. Every such operation runs on the single shared multiplier and
// reducer; the product is loaded in the cycle that starts it, and the sequencer
// then waits while the reducer takes one shift-subtract step per product bit and
// hands the result back. The scan ends once no set exponent bit remains; a zero
// modulus skips the scan and goes straight to the response, while a zero exponent
// ends at the first scan and returns the initial accumulator value of one.
// The block takes one item at a time; req_tready is high only while it is idle.
// A finished response sits in the output register until rsp_tready takes it;
// a new request may be accepted meanwhile, and its result waits if the output
// register is still occupied. Reset is synchronous and clears all control state;
// no response is pending after reset.
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // base[31:0], exponent[63:32], modulus[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // power_result[31:0]
   output logic        rsp_tuser    // zero_modulus_error
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          sq_ff, sq_in;
   logic [W-1:0]          exp_ff, exp_in;
   logic [W-1:0]          mod_ff, mod_in;
   logic                  err_ff, err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  req_beat;
   logic                  slot_free;
   logic                  unit_start;
   logic [W-1:0]          unit_op_a;
   logic [W-1:0]          unit_result;
   mulmod_status_type     unit_status;
   logic [W-1:0]          in_base;
   logic [W-1:0]          in_exp;
   logic [W-1:0]          in_mod;

   assign in_base   = req_tdata[W-1:0];
   assign in_exp    = req_tdata[DATA_WIDTH+W-1:DATA_WIDTH];
   assign in_mod    = req_tdata[2*DATA_WIDTH+W-1:2*DATA_WIDTH];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   assign unit_op_a  = (state_ff == ST_SCAN && exp_ff[0]) ? acc_ff : sq_ff;
   assign unit_start = (state_ff == ST_SCAN && exp_ff != '0) ||
                       (state_ff == ST_ACC && unit_status.done);

   mexp_mulmod #(
      .OPERAND_WIDTH(W)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .op_a    (unit_op_a),
      .op_b    (sq_ff),
      .modulus (mod_ff),
      .status  (unit_status),
      .result  (unit_result)
   );

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      err_in       = err_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               sq_in  = in_base;
               exp_in = in_exp;
               mod_in = in_mod;
               if (in_mod == '0) begin
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  acc_in   = W'(1);
                  err_in   = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_ACC;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_ACC: begin
            if (unit_status.done) begin
               acc_in   = unit_result;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (unit_status.done) begin
               sq_in    = unit_result;
               exp_in   = exp_ff >> 1;
               state_in = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = DATA_WIDTH'(acc_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTH
   // The shared unit is only started when it is free.
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      unit_start |-> !unit_status.busy)
      else $error("mulmod started while busy");

   // A finished operation is only handed back while the sequencer waits for it.
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      unit_status.done |-> (state_ff == ST_ACC || state_ff == ST_SQ))
      else $error("mulmod done outside a wait state");

   // An error response always carries a zero result.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("error response with nonzero result");
`endif

endmodule
